[hdl/pet_pkg.sv]
package pet_pkg;

    localparam int POS_W     = 12;
    localparam int DIM_W     = 13;
    localparam int TYPE_W    = 16;
    localparam int CODE_W    = 16;
    localparam int VAL_W     = 32;
    localparam int BTN_W     = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [TYPE_W-1:0] TYPE_KEY = 16'd1;
    localparam logic [TYPE_W-1:0] TYPE_REL = 16'd2;
    localparam logic [TYPE_W-1:0] TYPE_ABS = 16'd3;

    localparam logic [CODE_W-1:0] CODE_X     = 16'h0000;
    localparam logic [CODE_W-1:0] CODE_Y     = 16'h0001;
    localparam logic [CODE_W-1:0] CODE_LEFT  = 16'h0110;
    localparam logic [CODE_W-1:0] CODE_RIGHT = 16'h0111;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

    localparam logic [DIM_W-1:0] DIM_RESET_W = 13'd1024;
    localparam logic [DIM_W-1:0] DIM_RESET_H = 13'd768;
    localparam logic [DIM_W-1:0] DIM_MAX     = 13'd4096;

    localparam logic [BTN_W-1:0] MASK_LEFT  = 2'b01;
    localparam logic [BTN_W-1:0] MASK_RIGHT = 2'b10;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ABS_X,
        OP_ABS_Y,
        OP_REL_X,
        OP_REL_Y,
        OP_KEY_L,
        OP_KEY_R
    } t_op;

    // largest coordinate on an axis; zero is treated as one, oversize as DIM_MAX
    function automatic logic [POS_W-1:0] dim_hi(input logic [DIM_W-1:0] dim);
        if (dim == '0) begin
            return '0;
        end else if (dim > DIM_MAX) begin
            return '1;
        end else begin
            return POS_W'(dim - 13'd1);
        end
    endfunction

endpackage

[hdl/pointer_event_tracker.sv]
// Pipeline from input transaction to o_valid: input reg, scale product,
// reciprocal multiply, remainder, then the state/result register.
// Throughput: one event per cycle while i_ready is high; the stages advance independently so
// bubbles collapse and a held result does not block input until the pipeline is full.
// Reset (synchronous, active low): widths 1024/768, pointer at 512/384, no buttons.
module pointer_event_tracker #(
    parameter int ABS_MAX = 32767
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [pet_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pet_pkg::DIM_W-1:0]       i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [pet_pkg::TYPE_W-1:0]      i_event_type,
    input  logic [pet_pkg::CODE_W-1:0]      i_event_code,
    input  logic [pet_pkg::VAL_W-1:0]       i_event_value,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [pet_pkg::POS_W-1:0]       o_pointer_x,
    output logic [pet_pkg::POS_W-1:0]       o_pointer_y,
    output logic [pet_pkg::BTN_W-1:0]       o_button_mask
);
    import pet_pkg::*;

    localparam int CW    = $clog2(ABS_MAX + 1);
    localparam int PW    = CW + POS_W;
    localparam int REM_W = CW + 1;
    localparam int SUM_W = VAL_W + 2;
    localparam logic [PW:0] RECIP = (PW+1)'((64'd1 << PW) / ABS_MAX);

    // config
    logic [DIM_W-1:0] r_screen_width, r_screen_height;
    logic [POS_W-1:0] hi_x, hi_y;

    // state, doubles as the result register
    logic             r_out_valid;
    logic [POS_W-1:0] r_pos_x, r_pos_y, n_pos_x, n_pos_y;
    logic [BTN_W-1:0] r_btn, n_btn;

    // stage valids and advance enables
    logic r1_v, r2_v, r3_v, r4_v;
    logic en1, en2, en3, en4, adv_out;

    // stage payloads
    logic [TYPE_W-1:0] r1_type;
    logic [CODE_W-1:0] r1_code;
    logic [VAL_W-1:0]  r1_value, r2_value, r3_value, r4_value;
    t_op               r2_op, r3_op, r4_op, n2_op;
    logic [PW-1:0]     r2_prod, r3_prod, n2_prod, n4_qa;
    logic [CW-1:0]     n2_c;
    logic [POS_W-1:0]  n2_hi;
    logic [2*PW:0]     n3_pm;
    logic [POS_W-1:0]  r3_qest, r4_qest, n_abs;
    logic [REM_W-1:0]  r4_rem, n4_rem;

    // relative move
    logic [POS_W-1:0]        rel_base, rel_hi, n_rel;
    logic signed [SUM_W-1:0] n_sum;

    assign hi_x = dim_hi(r_screen_width);
    assign hi_y = dim_hi(r_screen_height);

    assign adv_out = !r_out_valid || i_ready;
    assign en4     = !r4_v || adv_out;
    assign en3     = !r3_v || en4;
    assign en2     = !r2_v || en3;
    assign en1     = !r1_v || en2;
    assign o_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= DIM_RESET_W;
            r_screen_height <= DIM_RESET_H;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_WIDTH:  r_screen_width  <= i_cfg_data;
                CFG_HEIGHT: r_screen_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
            r3_v        <= 1'b0;
            r4_v        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en1) begin
                r1_v <= i_valid;
            end
            if (en2) begin
                r2_v <= r1_v;
            end
            if (en3) begin
                r3_v <= r2_v;
            end
            if (en4) begin
                r4_v <= r3_v;
            end
            if (adv_out) begin
                r_out_valid <= r4_v;
            end
        end
    end

    // stage 1: input register
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_type  <= i_event_type;
            r1_code  <= i_event_code;
            r1_value <= i_event_value;
        end
    end

    // stage 2: decode, clamp and scale product
    always_comb begin
        n2_op = OP_NONE;
        if (r1_type == TYPE_ABS) begin
            if (r1_code == CODE_X) begin
                n2_op = OP_ABS_X;
            end else if (r1_code == CODE_Y) begin
                n2_op = OP_ABS_Y;
            end
        end else if (r1_type == TYPE_REL) begin
            if (r1_code == CODE_X) begin
                n2_op = OP_REL_X;
            end else if (r1_code == CODE_Y) begin
                n2_op = OP_REL_Y;
            end
        end else if (r1_type == TYPE_KEY) begin
            if (r1_code == CODE_LEFT) begin
                n2_op = OP_KEY_L;
            end else if (r1_code == CODE_RIGHT) begin
                n2_op = OP_KEY_R;
            end
        end
    end

    always_comb begin
        if (r1_value[VAL_W-1]) begin
            n2_c = '0;
        end else if (r1_value > VAL_W'(ABS_MAX)) begin
            n2_c = CW'(ABS_MAX);
        end else begin
            n2_c = r1_value[CW-1:0];
        end
    end

    assign n2_hi   = (r1_code == CODE_Y) ? hi_y : hi_x;
    assign n2_prod = PW'(n2_c) * PW'(n2_hi);

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_op    <= n2_op;
            r2_prod  <= n2_prod;
            r2_value <= r1_value;
        end
    end

    // stage 3: quotient estimate by reciprocal, low by at most one
    assign n3_pm = (2*PW+1)'(r2_prod) * (2*PW+1)'(RECIP);

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_op    <= r2_op;
            r3_prod  <= r2_prod;
            r3_qest  <= n3_pm[PW+POS_W-1:PW];
            r3_value <= r2_value;
        end
    end

    // stage 4: remainder of the estimate
    assign n4_qa  = PW'(r3_qest) * PW'(ABS_MAX);
    assign n4_rem = REM_W'(r3_prod - n4_qa);

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_op    <= r3_op;
            r4_qest  <= r3_qest;
            r4_rem   <= n4_rem;
            r4_value <= r3_value;
        end
    end

    // final stage: correct quotient, relative saturate, buttons
    assign n_abs = (r4_rem >= REM_W'(ABS_MAX)) ? r4_qest + 1'b1 : r4_qest;

    assign rel_base = (r4_op == OP_REL_Y) ? r_pos_y : r_pos_x;
    assign rel_hi   = (r4_op == OP_REL_Y) ? hi_y : hi_x;
    assign n_sum    = $signed({{(SUM_W-POS_W){1'b0}}, rel_base})
                    + $signed({{(SUM_W-VAL_W){r4_value[VAL_W-1]}}, r4_value});

    always_comb begin
        if (n_sum[SUM_W-1]) begin
            n_rel = '0;
        end else if (n_sum > $signed({{(SUM_W-POS_W){1'b0}}, rel_hi})) begin
            n_rel = rel_hi;
        end else begin
            n_rel = n_sum[POS_W-1:0];
        end
    end

    always_comb begin
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        n_btn   = r_btn;
        case (r4_op)
            OP_ABS_X: n_pos_x = n_abs;
            OP_ABS_Y: n_pos_y = n_abs;
            OP_REL_X: n_pos_x = n_rel;
            OP_REL_Y: n_pos_y = n_rel;
            OP_KEY_L: n_btn   = (r4_value != '0) ? (r_btn | MASK_LEFT) : (r_btn & ~MASK_LEFT);
            OP_KEY_R: n_btn   = (r4_value != '0) ? (r_btn | MASK_RIGHT)
                                                 : (r_btn & ~MASK_RIGHT);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= POS_W'(DIM_RESET_W >> 1);
            r_pos_y <= POS_W'(DIM_RESET_H >> 1);
            r_btn   <= '0;
        end else if (adv_out && r4_v) begin
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_btn   <= n_btn;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pointer_x   = r_pos_x;
    assign o_pointer_y   = r_pos_y;
    assign o_button_mask = r_btn;

endmodule

[hdl/pet_checker.sv]
module pet_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_ready,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic [pet_pkg::POS_W-1:0]       o_pointer_x,
    input logic [pet_pkg::POS_W-1:0]       o_pointer_y,
    input logic [pet_pkg::BTN_W-1:0]       o_button_mask
);
    import pet_pkg::*;

    logic [2*POS_W+BTN_W-1:0] result;
    assign result = {o_pointer_x, o_pointer_y, o_button_mask};

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(result)))
        else $error("result changed or dropped while stalled");

    // result leaves only through a transaction
    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_valid) |-> $past(i_ready))
        else $error("o_valid fell without a transaction");

    // pointer state moves only when a fresh result is presented
    a_state_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(result) |-> o_valid)
        else $error("pointer state changed without a result");

    // empty result slot means the pipeline can drain, so input is open
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with no pending result");

endmodule

bind pointer_event_tracker pet_checker u_pet_checker (.*);
